@@ design/gacq_pkg.sv @@
// gacq_pkg: shared types, constants and elaboration helpers of the grid cost query block
// depends on nothing; imported by every module of the block except gacq_ram
`default_nettype none

package gacq_pkg;

   // request and result payloads
   typedef struct packed {
      logic       func;
      logic [3:0] cell_row;
      logic [3:0] cell_col;
      logic [7:0] cell_value;
      logic [3:0] start_row;
      logic [3:0] start_col;
      logic [3:0] goal_row;
      logic [3:0] goal_col;
   } req_type;

   typedef struct packed {
      logic [19:0] path_cost;
      logic        reached;
   } rsp_type;

   // request function codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // score codes, unsigned q12.8
   localparam logic [19:0] G_INF      = 20'hFFFFF;
   localparam logic [19:0] G_MAX      = 20'hFFFFE;
   localparam logic [20:0] F_INF      = 21'h1FFFFF;
   localparam logic [20:0] F_MAX      = 21'h1FFFFE;
   localparam logic [20:0] OUT_MAX    = 21'h0FFFFF;
   localparam logic [19:0] STEP_ORTHO = 20'd256;
   localparam logic [19:0] STEP_DIAG  = 20'd362;

   // register map
   localparam logic [2:0] ADDR_PASS_LIMIT  = 3'd0;
   localparam logic [7:0] PASS_LIMIT_RESET = 8'd3;

   // per-cell search record
   typedef struct packed {
      logic        open;
      logic        closed;
      logic [19:0] g;
      logic [20:0] f;
   } cell_rec_type;

   // controller to datapath commands
   typedef struct packed {
      logic map_clr;
      logic map_wr;
      logic load_query;
      logic ptr_inc;
      logic rec_clr;
      logic sel_seed;
      logic seed_wr;
      logic scan_rd;
      logic close_wr;
      logic nb_rd;
      logic nb_wr;
      logic emit_miss;
      logic emit_hit;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic cell_ok;
      logic query_ok;
      logic ptr_last;
      logic nb_last;
      logic found;
      logic at_goal;
   } sts_type;

   // rounded square root of sq in q8, half up; used at elaboration only
   function automatic logic [19:0] root_q8(input int unsigned sq);
      longint unsigned v;
      longint unsigned r;
      longint unsigned t;
      int              b;
      v = longint'(sq) << 16;
      r = 0;
      for (b = 20; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= v) r = t;
      end
      if (v - r * r > r) r = r + 1;
      return 20'(r);
   endfunction

endpackage

`default_nettype wire

@@ design/grid_astar_cost_query.sv @@
// grid_astar_cost_query: top level, register port and controller/datapath assembly
// depends on gacq_pkg, gacq_ctrl, gacq_datapath
//
// Usage:
//   A request is taken when start is high and busy is low. func = write stores
//   cell_value into one map cell in that same cycle (cells outside the grid are
//   ignored) and gives no result; busy stays low. func = query runs an
//   8-connected a* search and gives exactly one result: rsp_valid is high for
//   one cycle with rsp_data. A query whose start or goal lies outside the grid
//   answers in the next cycle with path_cost 0, reached 0.
//   A query clears the search records, seeds the start cell, then per expansion
//   runs a minimum scan over the record memory and a neighbor relaxation, and
//   last registers the result. The scan over the record memory, one read port,
//   sets the query time.
//   After reset the map memory is swept to zero with busy high;
//   the pass_limit register (apb, byte address 0) reads back and resets to 3.
//   The receiver cannot stall: each result is shown for one cycle only.
`default_nettype none

module grid_astar_cost_query #(
   parameter int GRID_ROWS = 16,
   parameter int GRID_COLS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire gacq_pkg::req_type req_data,
   output logic                   rsp_valid,
   output gacq_pkg::rsp_type      rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   import gacq_pkg::*;

   cmd_type    cmd;
   sts_type    sts;
   logic [7:0] pass_limit_ff;

   // register port
   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_PASS_LIMIT) ? {24'd0, pass_limit_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_limit_ff <= PASS_LIMIT_RESET;
      end else if (psel && penable && pwrite && pready && paddr == ADDR_PASS_LIMIT) begin
         pass_limit_ff <= pwdata[7:0];
      end
   end

   // sequencer
   gacq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .func  (req_data.func),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   // search datapath
   gacq_datapath #(
      .GRID_ROWS (GRID_ROWS),
      .GRID_COLS (GRID_COLS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_data   (req_data),
      .pass_limit (pass_limit_ff),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

@@ design/gacq_ram.sv @@
// gacq_ram: generic single write port, single read port ram with registered read
// depends on nothing
`default_nettype none

module gacq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/gacq_ctrl.sv @@
// gacq_ctrl: sequencer of map clearing, map writes and the a* search
// depends on gacq_pkg
`default_nettype none

module gacq_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              func,
   output logic                   busy,
   output gacq_pkg::cmd_type      cmd,
   input  wire gacq_pkg::sts_type sts
);
   import gacq_pkg::*;

   typedef enum logic [9:0] {
      S_MAPCLR    = 10'b00_0000_0001,
      S_IDLE      = 10'b00_0000_0010,
      S_RECCLR    = 10'b00_0000_0100,
      S_SEED_RD   = 10'b00_0000_1000,
      S_SEED_WR   = 10'b00_0001_0000,
      S_SCAN      = 10'b00_0010_0000,
      S_SCAN_TAIL = 10'b00_0100_0000,
      S_PICK      = 10'b00_1000_0000,
      S_NB_RD     = 10'b01_0000_0000,
      S_NB_EVAL   = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_MAPCLR: begin
            cmd.map_clr = 1'b1;
            cmd.ptr_inc = 1'b1;
            if (sts.ptr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               if (func == FUNC_WRITE) begin
                  cmd.map_wr = sts.cell_ok;
               end else if (sts.query_ok) begin
                  cmd.load_query = 1'b1;
                  state_in       = S_RECCLR;
               end else begin
                  cmd.emit_miss = 1'b1;
               end
            end
         end
         S_RECCLR: begin
            cmd.rec_clr = 1'b1;
            cmd.ptr_inc = 1'b1;
            if (sts.ptr_last) state_in = S_SEED_RD;
         end
         S_SEED_RD: begin
            cmd.sel_seed = 1'b1;
            state_in     = S_SEED_WR;
         end
         S_SEED_WR: begin
            cmd.sel_seed = 1'b1;
            cmd.seed_wr  = 1'b1;
            state_in     = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            cmd.ptr_inc = 1'b1;
            if (sts.ptr_last) state_in = S_SCAN_TAIL;
         end
         S_SCAN_TAIL: begin
            state_in = S_PICK;
         end
         S_PICK: begin
            priority if (!sts.found) begin
               cmd.emit_miss = 1'b1;
               state_in      = S_IDLE;
            end else if (sts.at_goal) begin
               cmd.emit_hit = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmd.close_wr = 1'b1;
               state_in     = S_NB_RD;
            end
         end
         S_NB_RD: begin
            cmd.nb_rd = 1'b1;
            state_in  = S_NB_EVAL;
         end
         S_NB_EVAL: begin
            cmd.nb_wr = 1'b1;
            state_in  = sts.nb_last ? S_SCAN : S_NB_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_MAPCLR;
      else       state_ff <= state_in;
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

@@ design/gacq_datapath.sv @@
// gacq_datapath: map and record memories, scan minimum, neighbor relaxation and result
// depends on gacq_pkg and gacq_ram
`default_nettype none

module gacq_datapath #(
   parameter int GRID_ROWS = 16,
   parameter int GRID_COLS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire gacq_pkg::cmd_type cmd,
   output gacq_pkg::sts_type      sts,
   input  wire gacq_pkg::req_type req_data,
   input  wire logic [7:0]        pass_limit,
   output logic                   rsp_valid,
   output gacq_pkg::rsp_type      rsp_data
);
   import gacq_pkg::*;

   localparam int NCELLS = GRID_ROWS * GRID_COLS;
   localparam int ADDR_W = $clog2(NCELLS);
   localparam int ROW_W  = $clog2(GRID_ROWS);
   localparam int COL_W  = $clog2(GRID_COLS);
   localparam int REC_W  = $bits(cell_rec_type);
   localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(GRID_ROWS - 1);
   localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(GRID_COLS - 1);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(NCELLS - 1);

   // goal distance table, indexed by row offset * cols + column offset
   typedef logic [19:0] dist_tab_type [NCELLS];

   function automatic dist_tab_type build_dist();
      dist_tab_type tab;
      for (int r = 0; r < GRID_ROWS; r++) begin
         for (int c = 0; c < GRID_COLS; c++) begin
            tab[r * GRID_COLS + c] = root_q8(r * r + c * c);
         end
      end
      return tab;
   endfunction

   localparam dist_tab_type DIST_TAB = build_dist();

   // query registers
   logic [ROW_W-1:0]  start_row_ff, goal_row_ff;
   logic [COL_W-1:0]  start_col_ff, goal_col_ff;
   logic [ADDR_W-1:0] start_addr_ff, goal_addr_ff;

   // sweep pointer
   logic [ADDR_W-1:0] ptr_ff;
   logic [ROW_W-1:0]  ptr_row_ff;
   logic [COL_W-1:0]  ptr_col_ff;

   // scan pipeline and best candidate
   logic              scan_vld_ff;
   logic [ADDR_W-1:0] scan_addr_ff;
   logic [ROW_W-1:0]  scan_row_ff;
   logic [COL_W-1:0]  scan_col_ff;
   logic              found_ff;
   logic [20:0]       best_f_ff;
   logic [19:0]       best_g_ff;
   logic [ADDR_W-1:0] best_addr_ff;
   logic [ROW_W-1:0]  best_row_ff;
   logic [COL_W-1:0]  best_col_ff;

   // neighbor counter
   logic [3:0] nb_ff;

   // result
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   // memory ports
   logic              map_we;
   logic [ADDR_W-1:0] map_waddr, map_raddr;
   logic [7:0]        map_wdata, map_q;
   logic              rec_we;
   logic [ADDR_W-1:0] rec_waddr, rec_raddr;
   cell_rec_type      rec_wdata, rec_q;

   // request decode
   logic              cell_ok;
   logic [ADDR_W-1:0] cell_addr;
   logic [ADDR_W-1:0] req_start_addr, req_goal_addr;

   assign cell_ok = (32'(req_data.cell_row) < GRID_ROWS) && (32'(req_data.cell_col) < GRID_COLS);
   assign cell_addr = ADDR_W'(ROW_W'(req_data.cell_row)) * ADDR_W'(GRID_COLS)
                    + ADDR_W'(COL_W'(req_data.cell_col));
   assign req_start_addr = ADDR_W'(ROW_W'(req_data.start_row)) * ADDR_W'(GRID_COLS)
                         + ADDR_W'(COL_W'(req_data.start_col));
   assign req_goal_addr = ADDR_W'(ROW_W'(req_data.goal_row)) * ADDR_W'(GRID_COLS)
                        + ADDR_W'(COL_W'(req_data.goal_col));

   // neighbor offset decode
   logic row_dec, row_inc, col_dec, col_inc;

   always_comb begin
      row_dec = 1'b0;
      row_inc = 1'b0;
      col_dec = 1'b0;
      col_inc = 1'b0;
      unique case (nb_ff)
         4'd0:    begin row_dec = 1'b1; col_dec = 1'b1; end
         4'd1:    begin row_dec = 1'b1; end
         4'd2:    begin row_dec = 1'b1; col_inc = 1'b1; end
         4'd3:    begin col_dec = 1'b1; end
         4'd4:    begin end
         4'd5:    begin col_inc = 1'b1; end
         4'd6:    begin row_inc = 1'b1; col_dec = 1'b1; end
         4'd7:    begin row_inc = 1'b1; end
         4'd8:    begin row_inc = 1'b1; col_inc = 1'b1; end
         default: begin end
      endcase
   end

   // neighbor coordinates and bounds
   logic [ROW_W-1:0]  nb_row;
   logic [COL_W-1:0]  nb_col;
   logic              nb_ok;
   logic [ADDR_W-1:0] nb_addr;
   logic [19:0]       step;

   assign nb_row = row_dec ? best_row_ff - 1'b1 : (row_inc ? best_row_ff + 1'b1 : best_row_ff);
   assign nb_col = col_dec ? best_col_ff - 1'b1 : (col_inc ? best_col_ff + 1'b1 : best_col_ff);
   assign nb_ok  = !(row_dec && best_row_ff == '0) && !(row_inc && best_row_ff == ROW_LAST)
                && !(col_dec && best_col_ff == '0) && !(col_inc && best_col_ff == COL_LAST);
   assign nb_addr = ADDR_W'(nb_row) * ADDR_W'(GRID_COLS) + ADDR_W'(nb_col);
   assign step = ((row_dec || row_inc) && (col_dec || col_inc)) ? STEP_DIAG
               : ((row_dec || row_inc || col_dec || col_inc) ? STEP_ORTHO : 20'd0);

   // cell under evaluation: start cell while seeding, else the neighbor
   logic [ROW_W-1:0]  ev_row, dr_abs;
   logic [COL_W-1:0]  ev_col, dc_abs;
   logic [19:0]       hdist;
   logic [20:0]       tg_sum;
   logic [19:0]       tg, tg_use;
   logic [21:0]       f_sum;
   logic [20:0]       f_new;

   assign ev_row = cmd.sel_seed ? start_row_ff : nb_row;
   assign ev_col = cmd.sel_seed ? start_col_ff : nb_col;
   assign dr_abs = (ev_row >= goal_row_ff) ? ev_row - goal_row_ff : goal_row_ff - ev_row;
   assign dc_abs = (ev_col >= goal_col_ff) ? ev_col - goal_col_ff : goal_col_ff - ev_col;
   assign hdist  = DIST_TAB[ADDR_W'(dr_abs) * ADDR_W'(GRID_COLS) + ADDR_W'(dc_abs)];

   assign tg_sum = {1'b0, best_g_ff} + {1'b0, step};
   assign tg     = (tg_sum > {1'b0, G_MAX}) ? G_MAX : tg_sum[19:0];
   assign tg_use = cmd.sel_seed ? 20'd0 : tg;

   assign f_sum = {2'b00, tg_use} + {2'b00, hdist} + {6'd0, map_q, 8'd0};
   assign f_new = (map_q >= pass_limit) ? F_INF
                : ((f_sum > {1'b0, F_MAX}) ? F_MAX : f_sum[20:0]);

   // relaxation decision
   logic nb_update;
   assign nb_update = nb_ok && !rec_q.closed && (!rec_q.open || tg < rec_q.g);

   // map memory ports
   assign map_we    = cmd.map_clr || cmd.map_wr;
   assign map_waddr = cmd.map_clr ? ptr_ff : cell_addr;
   assign map_wdata = cmd.map_clr ? 8'd0 : req_data.cell_value;
   assign map_raddr = cmd.sel_seed ? start_addr_ff : nb_addr;

   // record memory ports
   assign rec_raddr = cmd.nb_rd ? nb_addr : ptr_ff;

   always_comb begin
      rec_we    = 1'b0;
      rec_waddr = nb_addr;
      rec_wdata = '{open: 1'b1, closed: 1'b0, g: tg, f: f_new};
      priority if (cmd.rec_clr) begin
         rec_we    = 1'b1;
         rec_waddr = ptr_ff;
         rec_wdata = '0;
      end else if (cmd.seed_wr) begin
         rec_we    = 1'b1;
         rec_waddr = start_addr_ff;
         rec_wdata = '{open: 1'b1, closed: 1'b0, g: 20'd0, f: f_new};
      end else if (cmd.close_wr) begin
         rec_we    = 1'b1;
         rec_waddr = best_addr_ff;
         rec_wdata = '{open: 1'b0, closed: 1'b1, g: best_g_ff, f: best_f_ff};
      end else if (cmd.nb_wr) begin
         rec_we = nb_update;
      end
   end

   gacq_ram #(.WIDTH(8), .DEPTH(NCELLS)) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (map_raddr),
      .rd_data (map_q)
   );

   logic [REC_W-1:0] rec_q_raw;

   gacq_ram #(.WIDTH(REC_W), .DEPTH(NCELLS)) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (rec_waddr),
      .wr_data (rec_wdata),
      .rd_addr (rec_raddr),
      .rd_data (rec_q_raw)
   );

   assign rec_q = cell_rec_type'(rec_q_raw);

   // query capture
   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         start_row_ff  <= ROW_W'(req_data.start_row);
         start_col_ff  <= COL_W'(req_data.start_col);
         goal_row_ff   <= ROW_W'(req_data.goal_row);
         goal_col_ff   <= COL_W'(req_data.goal_col);
         start_addr_ff <= req_start_addr;
         goal_addr_ff  <= req_goal_addr;
      end
   end

   // sweep pointer, wraps to zero after the last cell
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff     <= '0;
         ptr_row_ff <= '0;
         ptr_col_ff <= '0;
      end else if (cmd.ptr_inc) begin
         ptr_ff <= (ptr_ff == ADDR_LAST) ? '0 : ptr_ff + 1'b1;
         if (ptr_col_ff == COL_LAST) begin
            ptr_col_ff <= '0;
            ptr_row_ff <= (ptr_row_ff == ROW_LAST) ? '0 : ptr_row_ff + 1'b1;
         end else begin
            ptr_col_ff <= ptr_col_ff + 1'b1;
         end
      end
   end

   // scan read pipeline
   always_ff @(posedge clock) begin
      if (reset) scan_vld_ff <= 1'b0;
      else       scan_vld_ff <= cmd.scan_rd;
      scan_addr_ff <= ptr_ff;
      scan_row_ff  <= ptr_row_ff;
      scan_col_ff  <= ptr_col_ff;
   end

   // running minimum, first cell in row-major order wins ties
   logic        scan_first;
   logic [20:0] best_cmp;
   logic        scan_hit;

   assign scan_first = (scan_addr_ff == '0);
   assign best_cmp   = scan_first ? F_INF : best_f_ff;
   assign scan_hit   = rec_q.open && (rec_q.f < best_cmp);

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (scan_vld_ff) begin
         found_ff <= scan_hit || (!scan_first && found_ff);
      end
      if (scan_vld_ff) begin
         if (scan_hit) begin
            best_f_ff    <= rec_q.f;
            best_g_ff    <= rec_q.g;
            best_addr_ff <= scan_addr_ff;
            best_row_ff  <= scan_row_ff;
            best_col_ff  <= scan_col_ff;
         end else if (scan_first) begin
            best_f_ff <= F_INF;
         end
      end
   end

   // neighbor counter, wraps after the ninth offset
   always_ff @(posedge clock) begin
      if (reset)           nb_ff <= '0;
      else if (cmd.nb_wr)  nb_ff <= (nb_ff == 4'd8) ? 4'd0 : nb_ff + 1'b1;
   end

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= cmd.emit_miss || cmd.emit_hit;
      rsp_ff.reached   <= cmd.emit_hit;
      rsp_ff.path_cost <= !cmd.emit_hit ? 20'd0
                        : ((best_f_ff > OUT_MAX) ? 20'hFFFFF : best_f_ff[19:0]);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // status
   assign sts.cell_ok  = cell_ok;
   assign sts.query_ok = (32'(req_data.start_row) < GRID_ROWS)
                      && (32'(req_data.start_col) < GRID_COLS)
                      && (32'(req_data.goal_row) < GRID_ROWS)
                      && (32'(req_data.goal_col) < GRID_COLS);
   assign sts.ptr_last = (ptr_ff == ADDR_LAST);
   assign sts.nb_last  = (nb_ff == 4'd8);
   assign sts.found    = found_ff;
   assign sts.at_goal  = (best_addr_ff == goal_addr_ff);

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// testbench: self-checking bench for the grid cost query block, with its own a* search predictor
// depends on gacq_pkg and grid_astar_cost_query from the design folder
`timescale 1ns / 1ps

module testbench;
   import gacq_pkg::*;

   localparam int ROWS = 16;
   localparam int COLS = 16;
   localparam int CELLS = ROWS * COLS;
   localparam int CYCLE_LIMIT = 40_000_000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   grid_astar_cost_query uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // predictor state: map copy, limit copy, distance table
   logic [7:0]  map_copy [CELLS];
   logic [7:0]  limit_copy;
   int unsigned dist_q8 [ROWS][COLS];

   req_type     pending [$];
   rsp_type     cost_queue [$];
   int          errors;
   int          cycles;
   int          gap;
   bit          taken;
   bit          quiet;

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // mismatch reporting
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // append one request to the pending list
   task automatic add_request(input req_type q);
      pending.insert(pending.size(), q);
   endtask

   // rounded distance table, half up
   task automatic build_dist_table();
      longint unsigned v;
      longint unsigned r;
      for (int dr = 0; dr < ROWS; dr++) begin
         for (int dc = 0; dc < COLS; dc++) begin
            v = longint'(dr * dr + dc * dc) << 16;
            r = 0;
            while ((r + 1) * (r + 1) <= v) r++;
            if (v - r * r > r) r++;
            dist_q8[dr][dc] = int'(r);
         end
      end
   endtask

   // f of a cell: g + distance to goal + penalty, infinite when blocked
   function automatic int unsigned cell_score(input int unsigned g, input int idx,
                                              input int gr, input int gc);
      int unsigned v;
      int unsigned sum;
      int          dr;
      int          dc;
      v = map_copy[idx];
      if (v >= limit_copy) return F_INF;
      dr = idx / COLS - gr;
      dc = idx % COLS - gc;
      if (dr < 0) dr = -dr;
      if (dc < 0) dc = -dc;
      sum = g + dist_q8[dr][dc] + (v << 8);
      return (sum > F_MAX) ? F_MAX : sum;
   endfunction

   // 8-connected a* search from start to goal, returns the goal score
   function automatic rsp_type search_cost(input req_type q);
      bit          open_m [CELLS];
      bit          closed_m [CELLS];
      int unsigned g [CELLS];
      int unsigned f [CELLS];
      int unsigned best;
      int unsigned tg;
      int          s;
      int          goal;
      int          cur;
      int          nr;
      int          nc;
      int          n;
      rsp_type     res;
      res = '0;
      for (int i = 0; i < CELLS; i++) begin
         open_m[i] = 0;
         closed_m[i] = 0;
         g[i] = G_INF;
         f[i] = F_INF;
      end
      s = q.start_row * COLS + q.start_col;
      goal = q.goal_row * COLS + q.goal_col;
      open_m[s] = 1;
      g[s] = 0;
      f[s] = cell_score(0, s, q.goal_row, q.goal_col);
      forever begin
         cur = -1;
         best = F_INF;
         for (int i = 0; i < CELLS; i++) begin
            if (open_m[i] && f[i] < best) begin
               best = f[i];
               cur = i;
            end
         end
         if (cur < 0) return res;
         if (cur == goal) begin
            res.path_cost = (best > OUT_MAX) ? OUT_MAX[19:0] : best[19:0];
            res.reached = 1'b1;
            return res;
         end
         open_m[cur] = 0;
         closed_m[cur] = 1;
         for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
               nr = cur / COLS + dr;
               nc = cur % COLS + dc;
               if (nr < 0 || nr >= ROWS || nc < 0 || nc >= COLS) continue;
               n = nr * COLS + nc;
               if (closed_m[n]) continue;
               tg = g[cur] + dist_q8[(dr < 0) ? -dr : dr][(dc < 0) ? -dc : dc];
               if (tg > G_MAX) tg = G_MAX;
               if (!open_m[n]) open_m[n] = 1;
               else if (tg >= g[n]) continue;
               g[n] = tg;
               f[n] = cell_score(tg, n, q.goal_row, q.goal_col);
            end
         end
      end
   endfunction

   // request builders; unused fields are random so every bit toggles
   function automatic req_type map_write(input int r, input int c, input int v);
      req_type q;
      q = req_type'($bits(req_type)'({$urandom, $urandom}));
      q.func = FUNC_WRITE;
      q.cell_row = 4'(r);
      q.cell_col = 4'(c);
      q.cell_value = 8'(v);
      return q;
   endfunction

   function automatic req_type cost_query(input int sr, input int sc, input int gr, input int gc);
      req_type q;
      q = req_type'($bits(req_type)'({$urandom, $urandom}));
      q.func = FUNC_QUERY;
      q.start_row = 4'(sr);
      q.start_col = 4'(sc);
      q.goal_row = 4'(gr);
      q.goal_col = 4'(gc);
      return q;
   endfunction

   // register write with read-back
   task automatic write_pass_limit(input int value);
      @(negedge clock);
      psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
      paddr = ADDR_PASS_LIMIT; pwdata = 32'(value);
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      pwrite = 1'b0; penable = 1'b0;
      limit_copy = 8'(value);
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      if (prdata[7:0] !== 8'(value)) report_mismatch("pass_limit readback", prdata[7:0], value);
      @(negedge clock);
      psel = 1'b0; penable = 1'b0;
   endtask

   // wait until every request is taken and every result has come
   task automatic wait_drained();
      while (pending.size() != 0 || start || cost_queue.size() != 0 || busy)
         @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   // random map write, mostly passable values
   function automatic req_type random_write();
      int v;
      if (limit_copy != 0 && $urandom_range(0, 9) < 7) v = $urandom_range(0, limit_copy - 1);
      else v = $urandom_range(0, 255);
      return map_write($urandom_range(0, 15), $urandom_range(0, 15), v);
   endfunction

   // random query, mostly with the goal near the start
   function automatic req_type random_query();
      int sr;
      int sc;
      int gr;
      int gc;
      sr = $urandom_range(0, 15);
      sc = $urandom_range(0, 15);
      if ($urandom_range(0, 9) < 6) begin
         gr = sr + $urandom_range(0, 6) - 3;
         gc = sc + $urandom_range(0, 6) - 3;
         gr = (gr < 0) ? 0 : (gr > 15) ? 15 : gr;
         gc = (gc < 0) ? 0 : (gc > 15) ? 15 : gc;
      end else begin
         gr = $urandom_range(0, 15);
         gc = $urandom_range(0, 15);
      end
      return cost_query(sr, sc, gr, gc);
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || taken) begin
         taken = 0;
         if (gap > 0) begin
            gap--;
            start <= 1'b0;
         end else if (pending.size() != 0) begin
            if (!quiet && $urandom_range(0, 7) == 0) begin
               gap = $urandom_range(1, 19);
               start <= 1'b0;
            end else begin
               req_data <= pending.pop_front();
               start <= 1'b1;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // result checker and request predictor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (cost_queue.size() == 0) begin
               report_mismatch("unexpected result", rsp_data.path_cost, -1);
            end else begin
               if (rsp_data.path_cost !== cost_queue[0].path_cost)
                  report_mismatch("path_cost", rsp_data.path_cost, cost_queue[0].path_cost);
               if (rsp_data.reached !== cost_queue[0].reached)
                  report_mismatch("reached", rsp_data.reached, cost_queue[0].reached);
               void'(cost_queue.pop_front());
            end
         end
         if (start && !busy) begin
            taken = 1;
            if (req_data.func == FUNC_WRITE)
               map_copy[req_data.cell_row * COLS + req_data.cell_col] = req_data.cell_value;
            else
               cost_queue.insert(cost_queue.size(), search_cost(req_data));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // stimulus phases
   initial begin
      errors = 0; cycles = 0; gap = 0; taken = 0; quiet = 0;
      reset = 1'b1; start = 1'b0; req_data = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      limit_copy = PASS_LIMIT_RESET;
      for (int i = 0; i < CELLS; i++) map_copy[i] = 8'd0;
      build_dist_table();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      wait_drained();

      // directed: cleared map at the reset limit
      add_request(cost_query(0, 0, 15, 15));
      add_request(cost_query(5, 5, 5, 5));
      add_request(cost_query(15, 0, 0, 15));
      add_request(map_write(0, 0, 255));
      add_request(map_write(15, 15, 2));
      add_request(cost_query(0, 0, 15, 15));
      add_request(cost_query(15, 15, 15, 15));
      add_request(cost_query(1, 1, 15, 15));
      add_request(cost_query(0, 0, 0, 0));
      // goal walled in: search runs out of finite cells
      add_request(map_write(14, 15, 3));
      add_request(map_write(15, 14, 200));
      add_request(map_write(14, 14, 255));
      add_request(cost_query(8, 8, 15, 15));
      // impassable neighbor next to the path
      add_request(cost_query(14, 13, 13, 15));
      add_request(map_write(14, 15, 0));
      add_request(map_write(15, 14, 1));
      add_request(map_write(14, 14, 0));
      add_request(cost_query(13, 13, 15, 15));
      wait_drained();

      // widest limit: every value below 255 passes
      write_pass_limit(255);
      add_request(map_write(7, 7, 254));
      add_request(cost_query(7, 7, 7, 7));
      add_request(cost_query(0, 0, 15, 15));
      wait_drained();

      // zero limit: nothing passes
      write_pass_limit(0);
      add_request(cost_query(3, 4, 9, 10));
      add_request(cost_query(2, 2, 2, 2));
      wait_drained();

      // random phases over several limits, the last one without idling
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_pass_limit(1);
            1: write_pass_limit(4);
            2: write_pass_limit($urandom_range(2, 40));
            3: write_pass_limit(255);
            default: write_pass_limit(3);
         endcase
         quiet = (phase == 4);
         for (int k = 0; k < 16; k++)
            add_request(($urandom_range(0, 9) < 6) ? random_write() : random_query());
         wait_drained();
      end

      repeat (30) @(posedge clock);
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
